FILE: hw/rtl/tpsr_pkg.sv
`timescale 1ns / 1ps

package tpsr_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int FRAC_BITS  = 8;

    // s = 2b - a - c as a signed difference, and |s|, |t| as magnitudes
    localparam int DIFF_W = PIXEL_BITS + 2;
    localparam int MAG_W  = PIXEL_BITS + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = SQ_W + 1;
    // radicand padded to a whole number of bit pairs
    localparam int RAD_W  = SUM_W + (SUM_W % 2);
    localparam int ROOT_W = RAD_W / 2 + FRAC_BITS;
    localparam int REM_W  = ROOT_W + 3;
    localparam int NUM_CELLS = ROOT_W;
    localparam int NUM_SETS  = 2;

    // integer part of the halved root
    localparam int VALUE_W = ROOT_W - FRAC_BITS - 1;

    localparam int SETS_W = 2;
    localparam logic [SETS_W-1:0] PHASE_SETS_ONE = 2'd1;
    localparam logic [SETS_W-1:0] PHASE_SETS_TWO = 2'd2;

    localparam logic [PIXEL_BITS-1:0] SECTION_MAX = {PIXEL_BITS{1'b1}};

    localparam int IN_DATA_W  = 6 * PIXEL_BITS;
    localparam int OUT_DATA_W = PIXEL_BITS;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_root_lane;

    typedef struct packed {
        logic                      valid;
        logic                      two_sets;
        t_root_lane [NUM_SETS-1:0] lane;
    } t_cell_beat;

endpackage

FILE: hw/rtl/tpsr_front.sv
`timescale 1ns / 1ps

module tpsr_front
    import tpsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_take,
    input  logic                  i_two_sets,
    input  logic [IN_DATA_W-1:0]  i_pixels,
    output t_cell_beat            o_beat
);

    logic [PIXEL_BITS-1:0] w_a [NUM_SETS];
    logic [PIXEL_BITS-1:0] w_b [NUM_SETS];
    logic [PIXEL_BITS-1:0] w_c [NUM_SETS];
    logic signed [DIFF_W-1:0] w_s [NUM_SETS];
    logic signed [DIFF_W-1:0] w_t [NUM_SETS];

    logic [MAG_W-1:0] n_sm [NUM_SETS];
    logic [MAG_W-1:0] n_tm [NUM_SETS];
    logic [MAG_W-1:0] r_sm [NUM_SETS];
    logic [MAG_W-1:0] r_tm [NUM_SETS];
    logic [SQ_W-1:0]  r_ss [NUM_SETS];
    logic [SQ_W-1:0]  r_ts [NUM_SETS];
    logic [SUM_W-1:0] r_sum [NUM_SETS];

    logic [2:0] r_valid;
    logic [2:0] r_two;

    always_comb begin
        for (int k = 0; k < NUM_SETS; k++) begin
            w_a[k] = i_pixels[(3*k)*PIXEL_BITS +: PIXEL_BITS];
            w_b[k] = i_pixels[(3*k+1)*PIXEL_BITS +: PIXEL_BITS];
            w_c[k] = i_pixels[(3*k+2)*PIXEL_BITS +: PIXEL_BITS];
            w_s[k] = $signed({1'b0, w_b[k], 1'b0}) - $signed({2'b00, w_a[k]})
                   - $signed({2'b00, w_c[k]});
            w_t[k] = $signed({2'b00, w_c[k]}) - $signed({2'b00, w_a[k]});
            n_sm[k] = w_s[k][DIFF_W-1] ? MAG_W'(-w_s[k]) : MAG_W'(w_s[k]);
            n_tm[k] = w_t[k][DIFF_W-1] ? MAG_W'(-w_t[k]) : MAG_W'(w_t[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_take};
        end
    end

    // magnitudes, then squares, then the sum of squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_two <= {r_two[1:0], i_two_sets};
            for (int k = 0; k < NUM_SETS; k++) begin
                r_sm[k]  <= n_sm[k];
                r_tm[k]  <= n_tm[k];
                r_ss[k]  <= r_sm[k] * r_sm[k];
                r_ts[k]  <= r_tm[k] * r_tm[k];
                r_sum[k] <= SUM_W'(r_ss[k]) + SUM_W'(r_ts[k]);
            end
        end
    end

    always_comb begin
        o_beat.valid    = r_valid[2];
        o_beat.two_sets = r_two[2];
        for (int k = 0; k < NUM_SETS; k++) begin
            o_beat.lane[k].rem  = '0;
            o_beat.lane[k].root = '0;
            o_beat.lane[k].rad  = RAD_W'(r_sum[k]);
        end
    end

endmodule

FILE: hw/rtl/tpsr_cell.sv
`timescale 1ns / 1ps

module tpsr_cell
    import tpsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cell_beat i_beat,
    output t_cell_beat o_beat
);

    t_cell_beat n_beat;
    t_cell_beat r_beat;

    logic [REM_W-1:0] w_rem_sh [NUM_SETS];
    logic [REM_W-1:0] w_trial  [NUM_SETS];
    logic             w_ge     [NUM_SETS];

    // one result bit per set: bring down the next radicand pair and try it
    always_comb begin
        n_beat.valid    = i_beat.valid;
        n_beat.two_sets = i_beat.two_sets;
        for (int k = 0; k < NUM_SETS; k++) begin
            w_rem_sh[k] = {i_beat.lane[k].rem[REM_W-3:0],
                           i_beat.lane[k].rad[RAD_W-1 -: 2]};
            w_trial[k]  = REM_W'({i_beat.lane[k].root, 2'b01});
            w_ge[k]     = (w_rem_sh[k] >= w_trial[k]);
            n_beat.lane[k].rem  = w_ge[k] ? (w_rem_sh[k] - w_trial[k]) : w_rem_sh[k];
            n_beat.lane[k].root = {i_beat.lane[k].root[ROOT_W-2:0], w_ge[k]};
            n_beat.lane[k].rad  = {i_beat.lane[k].rad[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

FILE: hw/rtl/tpsr_out.sv
`timescale 1ns / 1ps

module tpsr_out
    import tpsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_beat            i_beat,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [0:0]            o_m_tuser,
    output logic                  o_stall
);

    logic [ROOT_W:0]       w_pair;
    logic [VALUE_W-1:0]    w_value;
    logic                  w_clip;
    logic [PIXEL_BITS-1:0] w_pixel;
    logic                  w_take;

    logic                  r_out_v;
    logic [PIXEL_BITS-1:0] r_out_pix;
    logic                  r_out_clip;
    logic                  r_skid_v;
    logic [PIXEL_BITS-1:0] r_skid_pix;
    logic                  r_skid_clip;

    // halve each root, and halve again for the mean of two sets
    always_comb begin
        w_pair = {1'b0, i_beat.lane[0].root} + {1'b0, i_beat.lane[1].root};
        if (i_beat.two_sets) begin
            w_value = w_pair[ROOT_W -: VALUE_W];
        end else begin
            w_value = i_beat.lane[0].root[ROOT_W-1 -: VALUE_W];
        end
        w_clip  = (w_value > VALUE_W'(SECTION_MAX));
        w_pixel = w_clip ? SECTION_MAX : w_value[PIXEL_BITS-1:0];
    end

    assign w_take = i_beat.valid && !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            r_out_v  <= r_skid_v || w_take;
            r_skid_v <= 1'b0;
        end else if (w_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out_pix  <= r_skid_pix;
                r_out_clip <= r_skid_clip;
            end else begin
                r_out_pix  <= w_pixel;
                r_out_clip <= w_clip;
            end
        end else if (w_take) begin
            // output held: park the beat in the skid stage
            r_skid_pix  <= w_pixel;
            r_skid_clip <= w_clip;
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = r_out_pix;
    assign o_m_tuser[0] = r_out_clip;
    assign o_stall      = r_skid_v;

endmodule

FILE: hw/rtl/three_phase_section_reconstruct_core.sv
// Pipeline: an input beat, once taken, passes three front stages, one cell per
//   root bit and one output register.
// Throughput: one pixel per cycle; the chain of square-root cells advances
//   as a whole and pauses only while the skid stage is full.
// Reset (i_rst_n low, synchronous): pipeline emptied, phase_sets set to one.
`timescale 1ns / 1ps

module three_phase_section_reconstruct_core
    import tpsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [SETS_W-1:0]     i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // first_phase_a, first_phase_b, first_phase_c,
    // second_phase_a, second_phase_b, second_phase_c
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // section_pixel
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // clipped
    output logic [0:0]            o_m_tuser
);

    logic [SETS_W-1:0] r_phase_sets;
    logic              w_en;
    logic              w_stall;
    logic              w_take;
    t_cell_beat        w_chain [NUM_CELLS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_sets <= PHASE_SETS_ONE;
        end else if (i_cfg_valid) begin
            r_phase_sets <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_en        = !w_stall;
    assign o_s_tready  = w_en;
    assign w_take      = i_s_tvalid && w_en;

    tpsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_take     (w_take),
        .i_two_sets (r_phase_sets == PHASE_SETS_TWO),
        .i_pixels   (i_s_tdata),
        .o_beat     (w_chain[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tpsr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    tpsr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (w_chain[NUM_CELLS]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_stall    (w_stall)
    );

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stall |-> o_m_tvalid)
        else $error("skid stage full with no beat on the output");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == SECTION_MAX))
        else $error("clipped beat not saturated");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !w_stall && !w_chain[NUM_CELLS].valid))
        else $error("pipeline not empty after reset");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench
    import tpsr_pkg::*;
();

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int CHUNK_ITEMS    = 116;
    localparam int CHUNKS_PER_RUN = 3;

    // register codes that the block treats as one-set mode as well
    localparam logic [SETS_W-1:0] SETS_CODE_ZERO  = 2'd0;
    localparam logic [SETS_W-1:0] SETS_CODE_THREE = 2'd3;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] c;
        logic [PIXEL_BITS-1:0] b;
        logic [PIXEL_BITS-1:0] a;
    } t_phase_set;

    // first set in the low bits, as on the bus
    typedef struct packed {
        t_phase_set second;
        t_phase_set first;
    } t_pixel_beat;

    typedef struct packed {
        logic                  clipped;
        logic [PIXEL_BITS-1:0] pixel;
    } t_section;

    typedef struct {
        logic [SETS_W-1:0] sets;
        t_pixel_beat       px;
        bit                typed;
        t_section          want;
    } t_stim_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [SETS_W-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    t_pixel_beat           s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_ready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;

    t_section          pending_sections[$];
    logic [SETS_W-1:0] model_sets = PHASE_SETS_ONE;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                errors = 0;
    int                cycles = 0;
    int                pixels_checked = 0;
    int                cfg_writes = 0;
    int                two_set_pixels = 0;
    t_stim_row         directed_rows[$];
    logic [SETS_W-1:0] chunk_sets [9] = '{PHASE_SETS_TWO, SETS_CODE_THREE, PHASE_SETS_ONE,
                                          PHASE_SETS_TWO, SETS_CODE_ZERO, PHASE_SETS_TWO,
                                          PHASE_SETS_ONE, SETS_CODE_THREE, PHASE_SETS_TWO};
    int                send_pct_by_run [3] = '{22, 47, 0};
    int                recv_pct_by_run [3] = '{47, 22, 0};

    three_phase_section_reconstruct_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sqrt(s*s + t*t) with FRAC_BITS fraction bits, truncated
    function automatic longint unsigned set_root(t_phase_set p);
        int              s_diff;
        int              t_diff;
        longint unsigned rad;
        longint unsigned trial;
        longint unsigned root;
        s_diff = 2 * int'(p.b) - int'(p.a) - int'(p.c);
        t_diff = int'(p.c) - int'(p.a);
        rad    = 64'(s_diff * s_diff + t_diff * t_diff) << (2 * FRAC_BITS);
        root   = 0;
        for (int i = 24; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= rad) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic t_section predict_section(t_pixel_beat px, logic [SETS_W-1:0] sets);
        longint unsigned value;
        t_section        res;
        // halving, and averaging in two-set mode, only move the binary point
        if (sets == PHASE_SETS_TWO) begin
            value = (set_root(px.first) + set_root(px.second)) >> (FRAC_BITS + 2);
        end else begin
            value = set_root(px.first) >> (FRAC_BITS + 1);
        end
        if (value > SECTION_MAX) begin
            res.pixel   = SECTION_MAX;
            res.clipped = 1'b1;
        end else begin
            res.pixel   = value[PIXEL_BITS-1:0];
            res.clipped = 1'b0;
        end
        return res;
    endfunction

    function automatic t_stim_row dir_row(logic [SETS_W-1:0] sets,
                                          int a1, int b1, int c1, int a2, int b2, int c2,
                                          bit typed, int want_pixel);
        t_stim_row r;
        r.sets         = sets;
        r.px.first.a   = a1[PIXEL_BITS-1:0];
        r.px.first.b   = b1[PIXEL_BITS-1:0];
        r.px.first.c   = c1[PIXEL_BITS-1:0];
        r.px.second.a  = a2[PIXEL_BITS-1:0];
        r.px.second.b  = b2[PIXEL_BITS-1:0];
        r.px.second.c  = c2[PIXEL_BITS-1:0];
        r.typed        = typed;
        r.want.pixel   = want_pixel[PIXEL_BITS-1:0];
        r.want.clipped = 1'b0;
        return r;
    endfunction

    // mix of flat, extreme and arbitrary phase triples
    function automatic t_phase_set rand_phase_set();
        t_phase_set p;
        int         base;
        int         v [3];
        base = $urandom_range(0, 255);
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
                0: v[k] = base + int'($urandom_range(0, 8)) - 4;
                1: v[k] = $urandom_range(0, 1) ? 255 : 0;
                default: v[k] = $urandom_range(0, 255);
            endcase
            if (v[k] < 0) v[k] = 0;
            if (v[k] > 255) v[k] = 255;
        end
        p.a = v[0][PIXEL_BITS-1:0];
        p.b = v[1][PIXEL_BITS-1:0];
        p.c = v[2][PIXEL_BITS-1:0];
        return p;
    endfunction

    task automatic add_row(input t_stim_row r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    task automatic note_error(input string msg);
        if (errors < 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        errors++;
    endtask

    task automatic send_pixel(input t_pixel_beat px, input bit typed, input t_section want);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        pending_sections.insert(pending_sections.size(),
                                typed ? want : predict_section(px, model_sets));
        if (model_sets == PHASE_SETS_TWO) two_set_pixels++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_sections.size() != 0) @(posedge clk);
    endtask

    task automatic write_phase_sets(input logic [SETS_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        model_sets = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : check_results
        t_section want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_sections.size() == 0) begin
                note_error($sformatf("unexpected beat pixel=%0d clipped=%0d",
                                     m_tdata, m_tuser));
            end else begin
                want = pending_sections.pop_front();
                pixels_checked++;
                if (m_tdata !== want.pixel) begin
                    note_error($sformatf("section_pixel expected %0d got %0d",
                                         want.pixel, m_tdata));
                end
                if (m_tuser[0] !== want.clipped) begin
                    note_error($sformatf("clipped expected %0d got %0d",
                                         want.clipped, m_tuser[0]));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_sections.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int directed_count;
        int random_count;
        directed_count = 0;
        random_count   = 0;

        // flat, extreme and ignored-second-set pixels in one-set mode (reset value)
        add_row(dir_row(PHASE_SETS_ONE,   0,   0,   0,   0,   0,   0, 1,   0));
        add_row(dir_row(PHASE_SETS_ONE,   0, 255,   0,   0,   0,   0, 1, 255));
        add_row(dir_row(PHASE_SETS_ONE, 255,   0, 255, 255, 255, 255, 1, 255));
        add_row(dir_row(PHASE_SETS_ONE, 255, 255, 255, 255, 255, 255, 1,   0));
        add_row(dir_row(PHASE_SETS_ONE,   0, 255, 255,   0,   0,   0, 0,   0));
        add_row(dir_row(PHASE_SETS_ONE, 255, 255,   0, 128,  64,  32, 0,   0));
        add_row(dir_row(PHASE_SETS_ONE,   0,   0,   0,   0, 255,   0, 1,   0));
        add_row(dir_row(PHASE_SETS_ONE,   1,   2,   4,   7,   9,  11, 0,   0));
        // codes zero and three behave as one set
        add_row(dir_row(SETS_CODE_ZERO,   0, 255,   0,   0,   0,   0, 1, 255));
        add_row(dir_row(SETS_CODE_ZERO,   0, 255, 255, 255,   0,   0, 0,   0));
        add_row(dir_row(SETS_CODE_THREE,  0, 255,   0,   0,   0,   0, 1, 255));
        add_row(dir_row(SETS_CODE_THREE, 255,  0, 255,   0, 255,   0, 1, 255));
        // two sets: mean of both values, then back to one set
        add_row(dir_row(PHASE_SETS_TWO,   0, 255,   0,   0, 255,   0, 1, 255));
        add_row(dir_row(PHASE_SETS_TWO,   0, 255,   0,   0,   0,   0, 1, 127));
        add_row(dir_row(PHASE_SETS_TWO,   0,   0,   0,   0, 255,   0, 1, 127));
        add_row(dir_row(PHASE_SETS_TWO,   0,   0,   0,   0,   0,   0, 1,   0));
        add_row(dir_row(PHASE_SETS_TWO, 255, 255, 255, 255, 255, 255, 1,   0));
        add_row(dir_row(PHASE_SETS_TWO,   0, 255, 255, 255,   0,   0, 0,   0));
        add_row(dir_row(PHASE_SETS_TWO,   1,   0,   0,   0,   0,   1, 0,   0));
        add_row(dir_row(PHASE_SETS_ONE,   0, 255,   0, 255,   0, 255, 1, 255));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].sets != model_sets) begin
                wait_drained();
                write_phase_sets(directed_rows[i].sets);
            end
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
            directed_count++;
        end

        // three runs, the last without idling, each split into chunks at different register settings
        for (int run = 0; run < 3; run++) begin
            send_idle_pct = send_pct_by_run[run];
            recv_idle_pct = recv_pct_by_run[run];
            for (int ch = 0; ch < CHUNKS_PER_RUN; ch++) begin
                wait_drained();
                write_phase_sets(chunk_sets[run * CHUNKS_PER_RUN + ch]);
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    t_pixel_beat px;
                    px.first  = rand_phase_set();
                    px.second = rand_phase_set();
                    send_pixel(px, 1'b0, '0);
                    random_count++;
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_sections.size() != 0) begin
            note_error($sformatf("%0d results never arrived", pending_sections.size()));
        end
        $display("Sent %0d pixels (%0d directed, %0d random), %0d in two-set mode.",
                 directed_count + random_count, directed_count, random_count, two_set_pixels);
        $display("Checked %0d results across %0d register writes, %0d mismatches.",
                 pixels_checked, cfg_writes, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
